// ===== hdl/vsha_pkg.sv =====
// Package: sizes, status codes and home-slot table for the voice slot allocator.
package vsha_pkg;

  localparam int unsigned SLOTS    = 8;
  localparam int unsigned SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W    = $clog2(SLOTS + 1);
  localparam int unsigned NOTE_W   = 8;
  localparam int unsigned SLOTF_W  = 3;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned NOTES    = 1 << NOTE_W;

  typedef enum logic [STATUS_W-1:0] {
    ST_ASSIGNED     = 3'd0,
    ST_SOUNDING     = 3'd1,
    ST_FULL         = 3'd2,
    ST_RELEASED     = 3'd3,
    ST_NOT_SOUNDING = 3'd4,
    ST_SILENT       = 3'd5
  } status_e;

  localparam logic [NOTE_W-1:0] SILENT_RESET = 8'd255;

  typedef logic [SLOT_W-1:0] home_tbl_t [NOTES];

  // Home slot of every note code: note modulo SLOTS, settled at elaboration.
  function automatic home_tbl_t build_home_tbl();
    home_tbl_t tbl;
    for (int i = 0; i < NOTES; i++) begin
      tbl[i] = SLOT_W'(i % SLOTS);
    end
    return tbl;
  endfunction

  localparam home_tbl_t HOME_TBL = build_home_tbl();

endpackage

// ===== hdl/vsha_if.sv =====
// Interfaces: request, result and configuration channels of the voice slot allocator.
interface vsha_req_if import vsha_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [NOTE_W-1:0] note_code;
  logic              is_release;

  modport source (output valid, output note_code, output is_release, input ready);
  modport sink   (input valid, input note_code, input is_release, output ready);
endinterface

interface vsha_rsp_if import vsha_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SLOTF_W-1:0]  slot;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output slot, output status, input ready);
  modport sink   (input valid, input slot, input status, output ready);
endinterface

interface vsha_cfg_if import vsha_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [NOTE_W-1:0] silent_code;

  modport source (output valid, output silent_code, input ready);
  modport sink   (input valid, input silent_code, output ready);
endinterface

// ===== hdl/voice_slot_hash_allocator_top.sv =====
// Top level: voice slot allocator over an open-addressed table with linear probing.
//
//   channel | dir | handshake     | payload
//   --------+-----+---------------+--------------------------------
//   req_i   | in  | valid / ready | note_code[7:0], is_release
//   rsp_o   | out | valid / ready | slot[2:0], status[2:0]
//   cfg_i   | in  | valid / ready | silent_code[7:0] (always ready)
//
// A full scan of an item has an accept step, one probe read per slot from the
// home slot on, and a compare step behind the last read.
// A hit ends the scan early; a silent code finishes without any probe read.
// Reset clears the busy bits and sets the silent code to 255; the note memory is
// not cleared, since an entry is only looked at while its busy bit is set.
// A scan that finishes while the output register is still full holds in place.
module voice_slot_hash_allocator_top import vsha_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  vsha_req_if.sink   req_i,
  vsha_rsp_if.source rsp_o,
  vsha_cfg_if.sink   cfg_i
);

  typedef enum logic {
    S_IDLE,
    S_PROBE
  } state_e;

  state_e              state_q;
  logic [NOTE_W-1:0]   silent_q;
  logic [NOTE_W-1:0]   note_q;
  logic                rel_q;
  logic                is_silent_q;
  logic [SLOT_W-1:0]   idx_q;       // next slot to read
  logic [CNT_W-1:0]    cnt_q;       // reads issued so far
  logic                chk_vld_q;   // a read result waits for its compare
  logic [SLOT_W-1:0]   chk_idx_q;
  logic                chk_busy_q;
  logic [NOTE_W-1:0]   rd_note_q;
  logic                free_found_q;
  logic [SLOT_W-1:0]   free_idx_q;
  logic [SLOTS-1:0]    busy_q;
  logic                out_vld_q;
  logic [SLOTF_W-1:0]  out_slot_q;
  status_e             out_status_q;

  logic [NOTE_W-1:0]   note_mem [SLOTS];

  logic                issue;
  logic                hit;
  logic                cur_free;
  logic                free_ok;
  logic [SLOT_W-1:0]   free_sel;
  logic                fin_want;
  logic                out_free;
  logic                fin_go;
  logic                step;
  logic                mem_we;
  logic                rel_clr;
  status_e             res_status;
  logic [SLOT_W-1:0]   res_idx;
  logic [SLOT_W-1:0]   idx_nxt;

  assign req_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready  = 1'b1;
  assign rsp_o.valid  = out_vld_q;
  assign rsp_o.slot   = out_slot_q;
  assign rsp_o.status = out_status_q;

  always_comb begin
    issue    = (cnt_q != CNT_W'(SLOTS));
    hit      = chk_vld_q && chk_busy_q && (rd_note_q == note_q);
    cur_free = chk_vld_q && !chk_busy_q;
    free_ok  = free_found_q || cur_free;
    free_sel = free_found_q ? free_idx_q : chk_idx_q;
    // finish on silent code, on a match, or once the compare of the last read is done
    fin_want = (state_q == S_PROBE) && (is_silent_q || hit || (chk_vld_q && !issue));
    out_free = !out_vld_q || rsp_o.ready;
    fin_go   = fin_want && out_free;
    step     = (state_q == S_PROBE) && !fin_want;
    idx_nxt  = (idx_q == SLOT_W'(SLOTS - 1)) ? '0 : idx_q + 1'b1;

    res_idx = '0;
    priority if (is_silent_q) begin
      res_status = ST_SILENT;
    end else if (hit) begin
      res_status = rel_q ? ST_RELEASED : ST_SOUNDING;
      res_idx    = chk_idx_q;
    end else if (rel_q) begin
      res_status = ST_NOT_SOUNDING;
    end else if (free_ok) begin
      res_status = ST_ASSIGNED;
      res_idx    = free_sel;
    end else begin
      res_status = ST_FULL;
    end

    mem_we  = fin_go && !is_silent_q && !hit && !rel_q && free_ok;
    rel_clr = fin_go && !is_silent_q && hit && rel_q;
  end

  // Note memory: one write port at the claimed slot, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      note_mem[free_sel] <= note_q;
    end
    if (step && issue) begin
      rd_note_q <= note_mem[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      silent_q     <= SILENT_RESET;
      busy_q       <= '0;
      out_vld_q    <= 1'b0;
      out_slot_q   <= '0;
      out_status_q <= ST_ASSIGNED;
      note_q       <= '0;
      rel_q        <= 1'b0;
      is_silent_q  <= 1'b0;
      idx_q        <= '0;
      cnt_q        <= '0;
      chk_vld_q    <= 1'b0;
      chk_idx_q    <= '0;
      chk_busy_q   <= 1'b0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
    end else begin
      if (cfg_i.valid) begin
        silent_q <= cfg_i.silent_code;
      end

      // drop the result once the sink takes it, unless a new one loads now
      if (out_vld_q && rsp_o.ready && !fin_go) begin
        out_vld_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            note_q       <= req_i.note_code;
            rel_q        <= req_i.is_release;
            is_silent_q  <= (req_i.note_code == silent_q);
            idx_q        <= HOME_TBL[req_i.note_code];
            cnt_q        <= '0;
            chk_vld_q    <= 1'b0;
            free_found_q <= 1'b0;
            state_q      <= S_PROBE;
          end
        end
        S_PROBE: begin
          if (fin_go) begin
            out_vld_q    <= 1'b1;
            out_slot_q   <= SLOTF_W'(res_idx);
            out_status_q <= res_status;
            chk_vld_q    <= 1'b0;
            if (mem_we) begin
              busy_q[free_sel] <= 1'b1;
            end
            if (rel_clr) begin
              busy_q[chk_idx_q] <= 1'b0;
            end
            state_q <= S_IDLE;
          end else if (step) begin
            // compare the slot read last cycle, remember the first free one
            if (cur_free && !free_found_q) begin
              free_found_q <= 1'b1;
              free_idx_q   <= chk_idx_q;
            end
            // advance the probe
            chk_vld_q <= issue;
            if (issue) begin
              chk_idx_q  <= idx_q;
              chk_busy_q <= busy_q[idx_q];
              idx_q      <= idx_nxt;
              cnt_q      <= cnt_q + 1'b1;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/vsha_checker.sv =====
// Checker: port-level assertions for the voice slot allocator, bound to the top level.
module vsha_checker import vsha_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                req_valid_i,
  input logic                req_ready_i,
  input logic                rsp_valid_i,
  input logic                rsp_ready_i,
  input logic [SLOTF_W-1:0]  rsp_slot_i,
  input logic [STATUS_W-1:0] rsp_status_i
);

  // a stalled result holds its value
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_slot_i) && $stable(rsp_status_i))
    else $error("result changed while stalled");

  // status code stays within the defined codes
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (rsp_status_i <= ST_SILENT))
    else $error("undefined status code");

  // outcomes without a slot report slot zero
  a_no_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i == ST_FULL || rsp_status_i == ST_NOT_SOUNDING ||
                    rsp_status_i == ST_SILENT) |-> (rsp_slot_i == '0))
    else $error("nonzero slot on a no-slot outcome");

  // the block works on one item at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("ready right after accept");

endmodule

bind voice_slot_hash_allocator_top vsha_checker u_vsha_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_slot_i   (rsp_o.slot),
  .rsp_status_i (rsp_o.status)
);

// ===== tb/sv/tb_top.sv =====
// Testbench for the voice slot allocator: directed press/release table, then random traffic.
module tb_top import vsha_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // Settle time after the last result: one full probe scan plus margin.
  localparam int unsigned SETTLE_CYCLES = SLOTS + 4;
  localparam int unsigned RAND_ITEMS    = 260;
  localparam int unsigned RAND_PHASES   = 3;
  localparam int unsigned POOL_N        = 10;
  localparam int unsigned MAX_REPORTS   = 10;
  // About 800 items, each at most a long sender gap, a full scan and a long
  // receiver stall, plus drains; taken several times over.
  localparam int unsigned CYCLE_LIMIT   = 200000;

  localparam logic KEY_PRESS   = 1'b0;
  localparam logic KEY_RELEASE = 1'b1;
  localparam logic TYPED       = 1'b1;
  localparam logic PREDICT     = 1'b0;

  typedef struct packed {
    logic [SLOTF_W-1:0] slot;
    status_e            status;
  } voice_answer_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  // One row of the directed table; for ROW_CFG the note field holds the new silent code.
  typedef struct packed {
    row_kind_e         kind;
    logic [NOTE_W-1:0] note;
    logic              rel;
    logic              typed;
    voice_answer_t     answer;
  } dir_row_t;

  localparam int unsigned DIR_ROWS = 26;

  // Rows marked TYPED carry an answer read straight off the behavior; the
  // rest take the predictor's answer.
  dir_row_t dir_rows [DIR_ROWS] = '{
    // silent code and empty table right after reset
    '{ROW_REQ, 8'd255, KEY_PRESS,   TYPED,   '{3'd0, ST_SILENT}},
    '{ROW_REQ, 8'd255, KEY_RELEASE, TYPED,   '{3'd0, ST_SILENT}},
    '{ROW_REQ, 8'd0,   KEY_RELEASE, TYPED,   '{3'd0, ST_NOT_SOUNDING}},
    '{ROW_REQ, 8'd0,   KEY_PRESS,   TYPED,   '{3'd0, ST_ASSIGNED}},
    '{ROW_REQ, 8'd0,   KEY_PRESS,   TYPED,   '{3'd0, ST_SOUNDING}},
    // collisions on home slot 0 and a wrap from slot 7
    '{ROW_REQ, 8'd8,   KEY_PRESS,   PREDICT, '{3'd0, ST_ASSIGNED}},
    '{ROW_REQ, 8'd16,  KEY_PRESS,   PREDICT, '{3'd0, ST_ASSIGNED}},
    '{ROW_REQ, 8'd15,  KEY_PRESS,   PREDICT, '{3'd0, ST_ASSIGNED}},
    '{ROW_REQ, 8'd23,  KEY_PRESS,   PREDICT, '{3'd0, ST_ASSIGNED}},
    '{ROW_REQ, 8'd254, KEY_PRESS,   PREDICT, '{3'd0, ST_ASSIGNED}},
    '{ROW_REQ, 8'd100, KEY_PRESS,   PREDICT, '{3'd0, ST_ASSIGNED}},
    '{ROW_REQ, 8'd5,   KEY_PRESS,   PREDICT, '{3'd0, ST_ASSIGNED}},
    // table now full
    '{ROW_REQ, 8'd77,  KEY_PRESS,   TYPED,   '{3'd0, ST_FULL}},
    '{ROW_REQ, 8'd8,   KEY_RELEASE, PREDICT, '{3'd0, ST_RELEASED}},
    '{ROW_REQ, 8'd8,   KEY_RELEASE, TYPED,   '{3'd0, ST_NOT_SOUNDING}},
    '{ROW_REQ, 8'd23,  KEY_PRESS,   PREDICT, '{3'd0, ST_SOUNDING}},
    '{ROW_REQ, 8'd128, KEY_PRESS,   PREDICT, '{3'd0, ST_ASSIGNED}},
    // silent code moved onto a sounding note: that slot stays busy
    '{ROW_CFG, 8'd0,   KEY_PRESS,   PREDICT, '{3'd0, ST_ASSIGNED}},
    '{ROW_REQ, 8'd0,   KEY_PRESS,   TYPED,   '{3'd0, ST_SILENT}},
    '{ROW_REQ, 8'd0,   KEY_RELEASE, TYPED,   '{3'd0, ST_SILENT}},
    '{ROW_REQ, 8'd255, KEY_PRESS,   TYPED,   '{3'd0, ST_FULL}},
    '{ROW_REQ, 8'd128, KEY_RELEASE, PREDICT, '{3'd0, ST_RELEASED}},
    '{ROW_REQ, 8'd255, KEY_PRESS,   PREDICT, '{3'd0, ST_ASSIGNED}},
    '{ROW_CFG, 8'd255, KEY_PRESS,   PREDICT, '{3'd0, ST_ASSIGNED}},
    '{ROW_REQ, 8'd255, KEY_RELEASE, TYPED,   '{3'd0, ST_SILENT}},
    '{ROW_REQ, 8'd0,   KEY_RELEASE, PREDICT, '{3'd0, ST_RELEASED}}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  vsha_req_if req_ch ();
  vsha_rsp_if rsp_ch ();
  vsha_cfg_if cfg_ch ();

  voice_slot_hash_allocator_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch),
    .cfg_i  (cfg_ch)
  );

  // Predictor copy of the voice table and the silent code.
  logic              voice_busy [SLOTS];
  logic [NOTE_W-1:0] voice_note [SLOTS];
  logic [NOTE_W-1:0] silent_now;
  logic [NOTE_W-1:0] note_pool [POOL_N];

  voice_answer_t answers_q [$];

  int unsigned tx_idle_pct = 13;
  int unsigned rx_idle_pct = 81;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned requests_sent = 0;
  int unsigned releases_sent = 0;
  int unsigned code_writes = 0;
  int unsigned status_tally [8];

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Work out one request's answer and update the table, as the block should.
  function automatic voice_answer_t allocate_voice(logic [NOTE_W-1:0] note, logic rel);
    voice_answer_t ans;
    int hit;
    int vacant;
    int idx;
    ans.slot = '0;
    hit = -1;
    vacant = -1;
    idx = int'(note) % SLOTS;
    // Probe every slot from home, wrapping; keep the first match and first hole.
    for (int n = 0; n < SLOTS; n++) begin
      if (hit < 0 && voice_busy[idx] && voice_note[idx] == note) hit = idx;
      if (vacant < 0 && !voice_busy[idx]) vacant = idx;
      idx = (idx + 1) % SLOTS;
    end
    if (note == silent_now) begin
      ans.status = ST_SILENT;
    end else if (rel == KEY_PRESS) begin
      if (hit >= 0) begin
        ans.slot = SLOTF_W'(hit);
        ans.status = ST_SOUNDING;
      end else if (vacant >= 0) begin
        voice_busy[vacant] = 1'b1;
        voice_note[vacant] = note;
        ans.slot = SLOTF_W'(vacant);
        ans.status = ST_ASSIGNED;
      end else begin
        ans.status = ST_FULL;
      end
    end else if (hit >= 0) begin
      voice_busy[hit] = 1'b0;
      ans.slot = SLOTF_W'(hit);
      ans.status = ST_RELEASED;
    end else begin
      ans.status = ST_NOT_SOUNDING;
    end
    return ans;
  endfunction

  // Fill the note pool: most share one home slot to force long probes and full tables.
  function automatic void refresh_pool();
    logic [NOTE_W-1:0] base;
    base = NOTE_W'($urandom_range(0, NOTES - 1));
    for (int i = 0; i < POOL_N; i++) begin
      note_pool[i] = (i < 6) ? base + NOTE_W'(i * SLOTS) : NOTE_W'($urandom_range(0, NOTES - 1));
    end
  endfunction

  // Choose the next random request: mostly pool presses and releases of live
  // notes, with some fully random items and some silent-code items.
  function automatic void pick_request(output logic [NOTE_W-1:0] note, output logic rel);
    int unsigned roll;
    int unsigned live_n;
    int unsigned live [SLOTS];
    roll = $urandom_range(0, 99);
    note = note_pool[$urandom_range(0, POOL_N - 1)];
    rel = KEY_PRESS;
    live_n = 0;
    if (roll < 3) begin
      note = silent_now;
      rel = 1'($urandom_range(0, 1));
    end else if (roll < 15) begin
      note = NOTE_W'($urandom_range(0, NOTES - 1));
      rel = 1'($urandom_range(0, 1));
    end else if (roll < 50) begin
      rel = KEY_RELEASE;
      for (int s = 0; s < SLOTS; s++) begin
        if (voice_busy[s] && voice_note[s] != silent_now) begin
          live[live_n] = s;
          live_n++;
        end
      end
      if (live_n != 0) note = voice_note[live[$urandom_range(0, live_n - 1)]];
    end
  endfunction

  function automatic void flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("mismatch: %s", msg);
  endfunction

  // Drop valid for a random number of cycles, as the current idle rate says.
  task automatic hold_off();
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // Present one request, wait for it to be taken, then queue its answer.
  task automatic send_request(logic [NOTE_W-1:0] note, logic rel, logic typed,
                              voice_answer_t given);
    voice_answer_t predicted;
    req_ch.valid <= 1'b1;
    req_ch.note_code <= note;
    req_ch.is_release <= rel;
    do @(posedge clk_i); while (!req_ch.ready);
    predicted = allocate_voice(note, rel);
    answers_q.push_back(typed ? given : predicted);
    status_tally[predicted.status]++;
    requests_sent++;
    if (rel == KEY_RELEASE) releases_sent++;
  endtask

  // Hold the sender until every answer is back and the last scan has settled.
  task automatic wait_for_results();
    req_ch.valid <= 1'b0;
    while (answers_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_silent_code(logic [NOTE_W-1:0] code);
    wait_for_results();
    cfg_ch.valid <= 1'b1;
    cfg_ch.silent_code <= code;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    silent_now = code;
    code_writes++;
  endtask

  // Receiver side: stall at the current idle rate.
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      rsp_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Compare every accepted result with the oldest queued answer.
  always @(posedge clk_i) begin : result_check
    voice_answer_t want;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      if (answers_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected result slot %0d code %0d",
                                rsp_ch.slot, rsp_ch.status));
      end else begin
        want = answers_q.pop_front();
        if (rsp_ch.slot !== want.slot || rsp_ch.status !== want.status) begin
          flag_mismatch($sformatf("slot exp %0d got %0d, code exp %0d (%s) got %0d",
                                  want.slot, rsp_ch.slot, want.status,
                                  want.status.name(), rsp_ch.status));
        end
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d answers outstanding", cycle_count,
               answers_q.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    logic [NOTE_W-1:0] note;
    logic              rel;
    logic [NOTE_W-1:0] next_code;
    // Drive every input known from time zero and clear the predictor.
    rst_ni = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.note_code = '0;
    req_ch.is_release = KEY_PRESS;
    cfg_ch.valid = 1'b0;
    cfg_ch.silent_code = '0;
    silent_now = SILENT_RESET;
    for (int s = 0; s < SLOTS; s++) voice_busy[s] = 1'b0;
    for (int i = 0; i < 8; i++) status_tally[i] = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: walk the table.
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        write_silent_code(dir_rows[i].note);
      end else begin
        hold_off();
        send_request(dir_rows[i].note, dir_rows[i].rel, dir_rows[i].typed,
                     dir_rows[i].answer);
      end
    end

    // Random part: three idle profiles, each with its own silent code.
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 13;
          rx_idle_pct = 81;
          next_code = NOTE_W'($urandom_range(1, NOTES - 2));
        end
        1: begin
          tx_idle_pct = 81;
          rx_idle_pct = 13;
          // Prefer a note that is sounding now, so its slot gets stuck.
          next_code = NOTE_W'($urandom_range(1, NOTES - 2));
          for (int s = 0; s < SLOTS; s++) begin
            if (voice_busy[s] && voice_note[s] != silent_now) next_code = voice_note[s];
          end
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          next_code = SILENT_RESET;
        end
      endcase
      refresh_pool();
      write_silent_code(next_code);
      for (int n = 0; n < RAND_ITEMS; n++) begin
        // Pause mid-phase until the block has answered everything.
        if (n == RAND_ITEMS / 2) wait_for_results();
        hold_off();
        pick_request(note, rel);
        send_request(note, rel, PREDICT, '0);
      end
    end

    wait_for_results();
    $display("run covered %0d requests (%0d releases) under %0d silent-code settings",
             requests_sent, releases_sent, code_writes + 1);
    $display("outcomes: %0d assigned, %0d sounding, %0d full, %0d released, %0d absent, %0d silent",
             status_tally[ST_ASSIGNED], status_tally[ST_SOUNDING], status_tally[ST_FULL],
             status_tally[ST_RELEASED], status_tally[ST_NOT_SOUNDING],
             status_tally[ST_SILENT]);
    if (mismatches == 0 && answers_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/vsha_pkg.sv
hdl/vsha_if.sv
hdl/voice_slot_hash_allocator_top.sv
hdl/vsha_checker.sv
tb/sv/tb_top.sv
